// ===== design/assert_macros.svh =====
// Assertion macros shared by the line point walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk edge outside reset.
`define LPW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define LPW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define LPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LPW_ASSERT(lbl, prop, msg)
`define LPW_ASSERT_IMPL(lbl, ante, cons, msg)
`define LPW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/lpw_pkg.sv =====
// Shared constants and types of the line point walker.
`timescale 1ns / 1ps

package lpw_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OUT_BITS       = 16;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd3;

	typedef struct packed {
		logic [OUT_BITS-1:0] point_x;
		logic [OUT_BITS-1:0] point_y;
		logic                last;
	} lpw_point_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} lpw_buf_stat_t;

endpackage

// ===== design/lpw_if.sv =====
// Valid/ready channel interfaces for step words and point words.
`timescale 1ns / 1ps

interface lpw_step_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lpw_point_if;
	import lpw_pkg::*;

	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] point_x;
	logic [OUT_BITS-1:0] point_y;
	logic                last;

	modport source (output valid, output point_x, output point_y, output last, input ready);
	modport sink (input valid, input point_x, input point_y, input last, output ready);
endinterface

// ===== design/lpw_out_buf.sv =====
// Two-entry output buffer: a result register backed by a skid register.
`timescale 1ns / 1ps

module lpw_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lpw_pkg::lpw_point_t   wr_word,
	output lpw_pkg::lpw_buf_stat_t stat,
	output logic                  rd_valid,
	output lpw_pkg::lpw_point_t   rd_word,
	input  logic                  rd_ready
);
	import lpw_pkg::*;

	logic       main_valid_q;
	logic       skid_valid_q;
	lpw_point_t main_q;
	lpw_point_t skid_q;
	logic       pop;

	assign pop = main_valid_q && rd_ready;

	// The user must push only while the skid register is empty; this buffer does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= wr_word;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= wr_word;
			end else begin
				skid_q <= wr_word;
			end
		end
	end

	assign stat.main_valid = main_valid_q;
	assign stat.skid_valid = skid_valid_q;
	assign rd_valid        = main_valid_q;
	assign rd_word         = main_q;

endmodule

// ===== design/line_point_walker_core.sv =====
// Top level of the line point walker: segment setup, stepping logic and output buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Line point walker. Program the segment through the write port (index 0 start_x,
// 1 start_y, 2 end_x, 3 end_y, only the low COORD_BITS bits kept; other indexes are
// ignored). Every step word yields exactly one point word: the walk follows the axis
// with the larger span (Y on a tie), moves one pixel per word on that axis, and places
// the other coordinate at start + trunc(n * minor_span / major_span) using an exact
// remainder accumulator. The point that lands on the end coordinate of the major axis
// has last set, and the next step word begins the walk again; restart = 1 begins it
// at once. A register write also makes the next word start a fresh walk. Throughput
// is one point per clock while step ready stays high: the only per-point work is one
// add, compare and subtract on the remainder plus the coordinate increments. The point
// of each accepted step is registered in the output buffer. The segment setup (spans,
// axis choice, directions) is held in registers derived from the configuration, so step
// ready is held low by a wait register in the cycle after each write and out of reset. A
// two-word output buffer lets one more step in while a point waits to be taken.
module line_point_walker_core #(
	parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpw_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [COORD_BITS-1:0]           cfg_data,
	lpw_step_if.sink                        step,
	lpw_point_if.source                     point
);
	import lpw_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AB = COORD_BITS + 1;

	// Configuration registers.
	logic [CB-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic          cfg_hit;

	// Segment setup derived from the configuration.
	logic [CB-1:0] adx, ady;
	logic          follow_x;
	logic          follow_x_q, maj_down_q, min_neg_q;
	logic [CB-1:0] smaj_q, emaj_q, smin_q, span_maj_q, span_min_q;
	logic          cfg_wait_q;

	// Walk state.
	logic          walking_q;
	logic [CB-1:0] major_q, minor_q;
	logic [AB-1:0] rem_q;

	// Step datapath.
	logic          push;
	logic          begin_walk;
	logic [AB-1:0] rem_sum, rem_adv, rem_nxt;
	logic          carry;
	logic [CB-1:0] major_adv, minor_adv, major_nxt, minor_nxt;
	logic [CB-1:0] px, py;
	logic          last_nxt;
	logic [CB+OUT_BITS-1:0] px_ext, py_ext;
	lpw_point_t    wr_word;

	// Output buffer.
	lpw_buf_stat_t buf_stat;
	logic          rd_valid;
	lpw_point_t    rd_word;

	always_comb begin
		case (cfg_idx)
			REG_START_X: cfg_hit = cfg_we;
			REG_START_Y: cfg_hit = cfg_we;
			REG_END_X:   cfg_hit = cfg_we;
			REG_END_Y:   cfg_hit = cfg_we;
			default:     cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_END_X:   end_x_q   <= cfg_data;
				REG_END_Y:   end_y_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Spans and axis choice; a tie follows Y.
	assign adx      = (end_x_q >= start_x_q) ? (end_x_q - start_x_q) : (start_x_q - end_x_q);
	assign ady      = (end_y_q >= start_y_q) ? (end_y_q - start_y_q) : (start_y_q - end_y_q);
	assign follow_x = adx > ady;

	// Refresh the setup every cycle; after a write it settles once these registers reload from the segment registers.
	always_ff @(posedge clk) begin
		follow_x_q <= follow_x;
		smaj_q     <= follow_x ? start_x_q : start_y_q;
		emaj_q     <= follow_x ? end_x_q : end_y_q;
		smin_q     <= follow_x ? start_y_q : start_x_q;
		span_maj_q <= follow_x ? adx : ady;
		span_min_q <= follow_x ? ady : adx;
		maj_down_q <= follow_x ? (end_x_q < start_x_q) : (end_y_q < start_y_q);
		min_neg_q  <= follow_x ? (end_y_q < start_y_q) : (end_x_q < start_x_q);
	end

	// Hold off steps while the setup registers catch up with the registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wait_q <= 1'b1;
		end else begin
			cfg_wait_q <= cfg_we;
		end
	end

	assign step.ready = !buf_stat.skid_valid && !cfg_wait_q;
	assign push       = step.valid && step.ready;

	// Advance the remainder; a wrap past the major span moves the minor axis by one.
	assign rem_sum   = rem_q + {1'b0, span_min_q};
	assign carry     = rem_sum >= {1'b0, span_maj_q};
	assign rem_adv   = carry ? (rem_sum - {1'b0, span_maj_q}) : rem_sum;
	assign major_adv = maj_down_q ? (major_q - CB'(1)) : (major_q + CB'(1));
	assign minor_adv = carry ? (min_neg_q ? (minor_q - CB'(1)) : (minor_q + CB'(1))) : minor_q;

	assign begin_walk = step.restart || !walking_q;
	assign major_nxt  = begin_walk ? smaj_q : major_adv;
	assign minor_nxt  = begin_walk ? smin_q : minor_adv;
	assign rem_nxt    = begin_walk ? '0 : rem_adv;
	assign last_nxt   = major_nxt == emaj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			major_q   <= '0;
			minor_q   <= '0;
			rem_q     <= '0;
		end else begin
			if (cfg_hit) begin
				walking_q <= 1'b0;
			end else if (push) begin
				walking_q <= !last_nxt;
			end
			if (push) begin
				major_q <= major_nxt;
				minor_q <= minor_nxt;
				rem_q   <= rem_nxt;
			end
		end
	end

	// Fit the coordinates to the 16-bit point fields: zero-extend or drop high bits.
	assign px     = follow_x_q ? major_nxt : minor_nxt;
	assign py     = follow_x_q ? minor_nxt : major_nxt;
	assign px_ext = {{OUT_BITS{1'b0}}, px};
	assign py_ext = {{OUT_BITS{1'b0}}, py};

	assign wr_word.point_x = px_ext[OUT_BITS-1:0];
	assign wr_word.point_y = py_ext[OUT_BITS-1:0];
	assign wr_word.last    = last_nxt;

	lpw_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_word  (wr_word),
		.stat     (buf_stat),
		.rd_valid (rd_valid),
		.rd_word  (rd_word),
		.rd_ready (point.ready)
	);

	assign point.valid   = rd_valid;
	assign point.point_x = rd_word.point_x;
	assign point.point_y = rd_word.point_y;
	assign point.last    = rd_word.last;

	// The skid register only fills behind a waiting result.
	`LPW_ASSERT_IMPL(a_skid_behind_main, buf_stat.skid_valid, buf_stat.main_valid, "skid word without result word")
	// Any write on the register port, spare indexes included, blocks the next step while the setup refreshes.
	`LPW_ASSERT_NEXT(a_cfg_blocks_step, cfg_we, !step.ready, "step accepted before setup refreshed")
	// Mid-walk the remainder always stays below the major span.
	`LPW_ASSERT_IMPL(a_rem_in_range, walking_q && !cfg_wait_q, rem_q < {1'b0, span_maj_q}, "remainder out of range")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the line point walker: segment walks, restarts and register writes.
`timescale 1ns / 1ps

module tb;
	import lpw_pkg::*;

	localparam int CW         = COORD_BITS_DEF;
	localparam int QUIET_MAX  = 1000;
	localparam int RAND_STEPS = 950;
	localparam int SETTLE     = 8;

	// Indexes past the end register; the block must ignore writes to them.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

	typedef enum logic [1:0] {
		ACT_STEP,
		ACT_WRITE,
		ACT_SYNC
	} act_t;

	typedef struct {
		act_t                    act;
		logic                    restart;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CW-1:0]           data;
	} plan_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CW-1:0]           cfg_data;

	lpw_step_if  step_ch();
	lpw_point_if point_ch();

	line_point_walker_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.step     (step_ch),
		.point    (point_ch)
	);

	// Work plan for the driver and the points still owed by the block.
	plan_t      plan_q[$];
	lpw_point_t points_due[$];

	// Walker shadow: segment registers and walk state.
	logic [CW-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
	logic [CW-1:0] walk_major;
	logic [CW-1:0] walk_minor_off;
	logic [CW:0]   walk_rem;
	logic          walk_on;

	// Register values the plan has queued so far, used to size each walk.
	int plan_reg[0:3];

	int  errors, n_steps, n_points, n_ends, n_writes, n_restarts, steps_planned;
	int  send_wait, take_wait, quiet;
	bit  send_calm, take_calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	// Register write into the shadow; spare indexes leave the walk untouched.
	task automatic store_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CW-1:0] data);
		case (idx)
		REG_START_X: begin
			seg_sx  = data;
			walk_on = 1'b0;
		end
		REG_START_Y: begin
			seg_sy  = data;
			walk_on = 1'b0;
		end
		REG_END_X: begin
			seg_ex  = data;
			walk_on = 1'b0;
		end
		REG_END_Y: begin
			seg_ey  = data;
			walk_on = 1'b0;
		end
		default: ;
		endcase
	endtask

	// Advance the walk by one step word and return the point it must produce.
	function automatic lpw_point_t next_point(input logic restart);
		logic [CW-1:0] adx, ady, s_maj, e_maj, s_min, e_min, span_maj, span_min, minor;
		logic          x_major, maj_down, min_neg;
		lpw_point_t    p;
		adx      = (seg_ex >= seg_sx) ? seg_ex - seg_sx : seg_sx - seg_ex;
		ady      = (seg_ey >= seg_sy) ? seg_ey - seg_sy : seg_sy - seg_ey;
		// ties go to Y
		x_major  = adx > ady;
		s_maj    = x_major ? seg_sx : seg_sy;
		e_maj    = x_major ? seg_ex : seg_ey;
		s_min    = x_major ? seg_sy : seg_sx;
		e_min    = x_major ? seg_ey : seg_ex;
		span_maj = x_major ? adx : ady;
		span_min = x_major ? ady : adx;
		maj_down = e_maj < s_maj;
		min_neg  = e_min < s_min;
		if (restart || !walk_on) begin
			walk_major     = s_maj;
			walk_minor_off = '0;
			walk_rem       = '0;
		end else begin
			walk_major = maj_down ? walk_major - 1'b1 : walk_major + 1'b1;
			// remainder holds n*span_min mod span_maj; carry into the minor offset
			walk_rem = walk_rem + {1'b0, span_min};
			if (walk_rem >= {1'b0, span_maj}) begin
				walk_rem       = walk_rem - {1'b0, span_maj};
				walk_minor_off = walk_minor_off + 1'b1;
			end
		end
		p.last    = (walk_major == e_maj);
		walk_on   = !p.last;
		minor     = min_neg ? s_min - walk_minor_off : s_min + walk_minor_off;
		p.point_x = x_major ? walk_major : minor;
		p.point_y = x_major ? minor : walk_major;
		return p;
	endfunction

	task automatic report_miss(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic plan_step(input logic restart);
		plan_t it;
		it.act     = ACT_STEP;
		it.restart = restart;
		it.idx     = '0;
		it.data    = '0;
		plan_q.insert(plan_q.size(), it);
		steps_planned++;
	endtask

	task automatic plan_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CW-1:0] data);
		plan_t it;
		it.act     = ACT_WRITE;
		it.restart = 1'b0;
		it.idx     = idx;
		it.data    = data;
		plan_q.insert(plan_q.size(), it);
		if (idx <= REG_END_Y)
			plan_reg[idx] = int'(data);
	endtask

	task automatic plan_sync();
		plan_t it;
		it.act     = ACT_SYNC;
		it.restart = 1'b0;
		it.idx     = '0;
		it.data    = '0;
		plan_q.insert(plan_q.size(), it);
	endtask

	task automatic plan_segment(input int sx, input int sy, input int ex, input int ey);
		plan_write(REG_START_X, sx[CW-1:0]);
		plan_write(REG_START_Y, sy[CW-1:0]);
		plan_write(REG_END_X, ex[CW-1:0]);
		plan_write(REG_END_Y, ey[CW-1:0]);
	endtask

	// Coordinate near the edges of the plane now and then.
	function automatic int pick_coord();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_end(input int base, input int span);
		int d, r;
		d = $urandom_range(0, span);
		r = $urandom_range(0, 1) ? base + d : base - d;
		if (r > 65535)
			r = base - d;
		if (r < 0)
			r = base + d;
		if (r > 65535)
			r = 65535;
		return r;
	endfunction

	// Step driver: present planned words, hold writes until the block is idle.
	always @(posedge clk or negedge arst_n) begin
		logic  hold_valid;
		logic  hold_restart;
		logic  do_write;
		logic  drained;
		plan_t head;
		if (!arst_n) begin
			step_ch.valid   <= 1'b0;
			step_ch.restart <= 1'b0;
			cfg_we          <= 1'b0;
			cfg_idx         <= '0;
			cfg_data        <= '0;
			send_wait        = 0;
		end else begin
			hold_valid   = step_ch.valid;
			hold_restart = step_ch.restart;
			do_write     = 1'b0;
			if (step_ch.valid && step_ch.ready) begin
				points_due.insert(points_due.size(), next_point(step_ch.restart));
				n_steps++;
				if (step_ch.restart)
					n_restarts++;
				hold_valid = 1'b0;
				send_wait  = draw_wait(send_calm);
				if ($urandom_range(0, 59) == 0)
					send_calm = !send_calm;
			end
			// idle means nothing owed and no point word on the bus right now
			drained      = (points_due.size() == 0) && !point_ch.valid;
			if (!hold_valid) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (plan_q.size() > 0) begin
					head = plan_q[0];
					case (head.act)
					ACT_STEP: begin
						hold_valid   = 1'b1;
						hold_restart = head.restart;
						void'(plan_q.pop_front());
					end
					ACT_WRITE: begin
						if (drained) begin
							do_write  = 1'b1;
							cfg_idx  <= head.idx;
							cfg_data <= head.data;
							store_reg(head.idx, head.data);
							n_writes++;
							void'(plan_q.pop_front());
						end
					end
					ACT_SYNC: begin
						// hold the sender until every owed point is back
						if (drained)
							void'(plan_q.pop_front());
					end
					default: void'(plan_q.pop_front());
					endcase
				end
			end
			step_ch.valid   <= hold_valid;
			step_ch.restart <= hold_restart;
			cfg_we          <= do_write;
		end
	end

	// Point monitor: stall at random and check each word against the oldest owed point.
	always @(posedge clk or negedge arst_n) begin
		lpw_point_t want;
		if (!arst_n) begin
			point_ch.ready <= 1'b0;
			take_wait       = 0;
		end else begin
			if (point_ch.valid && point_ch.ready) begin
				n_points++;
				if (point_ch.last)
					n_ends++;
				if (points_due.size() == 0) begin
					report_miss($sformatf("point (%0d,%0d) last=%0b with none owed",
						point_ch.point_x, point_ch.point_y, point_ch.last));
				end else begin
					want = points_due.pop_front();
					if (point_ch.point_x !== want.point_x)
						report_miss($sformatf("point %0d: x got %0d want %0d",
							n_points, point_ch.point_x, want.point_x));
					if (point_ch.point_y !== want.point_y)
						report_miss($sformatf("point %0d: y got %0d want %0d",
							n_points, point_ch.point_y, want.point_y));
					if (point_ch.last !== want.last)
						report_miss($sformatf("point %0d: last got %0b want %0b",
							n_points, point_ch.last, want.last));
				end
				take_wait = draw_wait(take_calm);
				if ($urandom_range(0, 59) == 0)
					take_calm = !take_calm;
			end else if (take_wait > 0) begin
				take_wait--;
			end
			point_ch.ready <= (take_wait == 0);
		end
	end

	// Watchdog: drop the run when no word moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((step_ch.valid && step_ch.ready) || (point_ch.valid && point_ch.ready)
				|| cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("%0t ns watchdog: no word moved for %0d cycles", $time, QUIET_MAX);
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int sx, sy, ex, ey, span, full, n, roll;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = '0;
		cfg_data        = '0;
		step_ch.valid   = 1'b0;
		step_ch.restart = 1'b0;
		point_ch.ready  = 1'b0;
		seg_sx = '0;
		seg_sy = '0;
		seg_ex = '0;
		seg_ey = '0;
		walk_major     = '0;
		walk_minor_off = '0;
		walk_rem       = '0;
		walk_on        = 1'b0;
		plan_reg       = '{default: 0};
		errors = 0; n_steps = 0; n_points = 0; n_ends = 0; n_writes = 0;
		n_restarts = 0; steps_planned = 0; quiet = 0;
		send_calm = 1'b0;
		take_calm = 1'b0;

		// Directed: reset segment is a single point at the origin.
		plan_step(1'b0);
		plan_step(1'b1);
		// Tie in span goes to Y; Y walks down, X climbs; run one past the end.
		plan_segment(10, 20, 13, 17);
		repeat (5) plan_step(1'b0);
		// X-major walking down from the top edge, restart in the middle.
		plan_segment(65535, 0, 65531, 2);
		plan_step(1'b0);
		plan_step(1'b0);
		plan_step(1'b1);
		repeat (4) plan_step(1'b0);
		// Full-range spans exercise the widest remainder; walk only the head.
		plan_segment(0, 0, 65535, 65534);
		repeat (5) plan_step(1'b0);
		// A spare index write must not break the walk in progress.
		plan_write(REG_SPARE_LAST, 16'hFFFF);
		plan_sync();
		repeat (2) plan_step(1'b0);

		// Random: mostly complete walks of short segments, some broken and some long.
		while (steps_planned < RAND_STEPS + 21) begin
			roll = $urandom_range(0, 99);
			span = (roll < 8) ? 65535 : (roll < 40) ? 3 : 24;
			sx   = pick_coord();
			sy   = pick_coord();
			ex   = pick_end(sx, span);
			ey   = pick_end(sy, span);
			if ($urandom_range(0, 9) == 0)
				plan_write(CFG_IDX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
					CW'($urandom_range(0, 65535)));
			// usually rewrite every register, sometimes keep an old one
			if ($urandom_range(0, 4) != 0) plan_write(REG_START_X, sx[CW-1:0]);
			if ($urandom_range(0, 4) != 0) plan_write(REG_START_Y, sy[CW-1:0]);
			if ($urandom_range(0, 4) != 0) plan_write(REG_END_X, ex[CW-1:0]);
			if ($urandom_range(0, 4) != 0) plan_write(REG_END_Y, ey[CW-1:0]);
			full = plan_reg[REG_END_X] - plan_reg[REG_START_X];
			if (full < 0) full = -full;
			n = plan_reg[REG_END_Y] - plan_reg[REG_START_Y];
			if (n < 0) n = -n;
			if (n > full) full = n;
			full++;
			if (full > 40)
				n = $urandom_range(5, 40);
			else if ($urandom_range(0, 6) == 0)
				n = $urandom_range(1, full);
			else
				n = full + $urandom_range(0, 3);
			repeat (n) begin
				plan_step($urandom_range(0, 24) == 0);
				if ($urandom_range(0, 59) == 0)
					plan_write(CFG_IDX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
						CW'($urandom_range(0, 65535)));
				if ($urandom_range(0, 79) == 0)
					plan_sync();
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Advance until the plan is spent and every owed point is back, then settle.
		while (plan_q.size() > 0 || step_ch.valid || points_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (points_due.size() > 0)
			report_miss($sformatf("%0d points never arrived", points_due.size()));
		$display("tb: %0d step words (%0d with restart), %0d point words, %0d segment ends",
			n_steps, n_restarts, n_points, n_ends);
		$display("tb: %0d register writes including spare indexes, %0d mismatches",
			n_writes, errors);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
